// ===== rtl/double_hash_open_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double hash open table
// Short forms for implication checks, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_OPEN_TABLE_MACROS_SVH
`define DOUBLE_HASH_OPEN_TABLE_MACROS_SVH

// Same-cycle implication.
`define DHOT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DHOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dhot_pkg.sv =====
// ----------------------------------------------------------------------------
// dhot_pkg
// Shared constants and control types of the double hash open table.
// ----------------------------------------------------------------------------
`default_nettype none

package dhot_pkg;

    localparam int TABLE_SIZE = 32768;
    localparam int KEY_BYTES  = 7;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int CNT_W      = IDX_W + 1;
    localparam int ENTRY_W    = KEY_W + 2;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [31:0] DJB_INIT = 32'd5381;
    localparam logic [31:0] MUR_INIT = 32'd97777;
    localparam logic [31:0] MUR_MULT = 32'h5bd1e995;
    localparam logic [10:0] AUX_INIT = 11'd101;

    typedef struct packed {
        logic       load_in;
        logic       hash_step;
        logic       probe_init;
        logic       probe_rd;
        logic       probe_adv;
        logic       clear_wr;
        logic       wr_insert;
        logic       wr_delete;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_use_slot;
    } dhot_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       table_full;
        logic       hash_last;
        logic       walk_end;
        logic       occ;
        logic       tomb;
        logic       key_match;
        logic       clear_last;
        logic       out_free;
    } dhot_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dhot_ram.sv =====
// ----------------------------------------------------------------------------
// dhot_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dhot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/dhot_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhot_ctrl
// Sequencer: clearing pass, hashing, probe walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dhot_ctrl
    import dhot_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dhot_stat_t st,
    output dhot_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_HASH, S_PINIT, S_PRD, S_PCHK, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] rstat_reg, rstat_next;
    logic       ruse_reg, ruse_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        rstat_next = rstat_reg;
        ruse_next  = ruse_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ruse_next = 1'b0;
                if (st.op != OP_INSERT && st.op != OP_SEARCH && st.op != OP_DELETE)
                begin
                    rstat_next = ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else if (st.op == OP_INSERT && st.table_full)
                begin
                    rstat_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (st.hash_last)
                begin
                    state_next = S_PINIT;
                end
            end
            S_PINIT:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_PRD;
            end
            S_PRD:
            begin
                if (st.walk_end)
                begin
                    rstat_next = (st.op == OP_INSERT) ? ST_FULL : ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.probe_rd = 1'b1;
                    state_next   = S_PCHK;
                end
            end
            S_PCHK:
            begin
                state_next = S_DONE;
                if (st.op == OP_INSERT)
                begin
                    if (!st.occ)
                    begin
                        cmd.wr_insert = 1'b1;
                        rstat_next    = ST_OK;
                        ruse_next     = 1'b1;
                    end
                    else if (st.key_match)
                    begin
                        rstat_next = ST_DUP;
                    end
                    else
                    begin
                        cmd.probe_adv = 1'b1;
                        state_next    = S_PRD;
                    end
                end
                else
                begin
                    if (!st.occ && !st.tomb)
                    begin
                        rstat_next = ST_NOTFOUND;
                    end
                    else if (st.occ && st.key_match)
                    begin
                        cmd.wr_delete = (st.op == OP_DELETE);
                        rstat_next    = ST_OK;
                        ruse_next     = 1'b1;
                    end
                    else
                    begin
                        cmd.probe_adv = 1'b1;
                        state_next    = S_PRD;
                    end
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.res_status   = rstat_reg;
        cmd.res_use_slot = ruse_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            rstat_reg <= ST_NOTFOUND;
            ruse_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rstat_reg <= rstat_next;
            ruse_reg  <= ruse_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dhot_dp.sv =====
// ----------------------------------------------------------------------------
// dhot_dp
// Datapath: hash units, probe position, table memory, counts and result.
// ----------------------------------------------------------------------------
`default_nettype none

module dhot_dp
    import dhot_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dhot_cmd_t        cmd,
    input  wire logic [1:0]       in_op,
    input  wire logic [KEY_W-1:0] in_key,
    input  wire logic             hash_select,
    input  wire logic             m_tready,
    output dhot_stat_t            st,
    output logic                  m_tvalid,
    output logic [39:0]           m_tdata   // status[1:0], slot[16:2], probe_count[32:17]
);

    logic [1:0]       op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] hkey_reg, hkey_next;
    logic [2:0]       bcnt_reg, bcnt_next;
    logic [31:0]      h1_reg, h1_next;
    logic [10:0]      h2_reg, h2_next;
    logic [31:0]      pos_reg, pos_next;
    logic [CNT_W-1:0] pcnt_reg, pcnt_next;
    logic [IDX_W-1:0] clr_reg;
    logic [15:0]      ecnt_reg, ecnt_next;
    logic             ovalid_reg;
    logic [1:0]       rstat_reg;
    logic [IDX_W-1:0] rslot_reg;
    logic [15:0]      rprobe_reg;

    logic [7:0]         hbyte;
    logic [31:0]        mur_x, mur_p;
    logic [10:0]        aux_r;
    logic [IDX_W-1:0]   idx;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    assign hbyte = hkey_reg[KEY_W-1 -: 8];
    assign idx   = pos_reg[IDX_W-1:0];

    // One key byte per cycle through both hashes.
    always_comb
    begin
        mur_x     = h1_reg ^ {24'd0, hbyte};
        mur_p     = mur_x * MUR_MULT;
        aux_r     = {3'd0, hbyte};
        if (aux_r >= h2_reg)
        begin
            aux_r = aux_r - h2_reg;
        end
        if (aux_r >= h2_reg)
        begin
            aux_r = aux_r - h2_reg;
        end
        hkey_next = hkey_reg;
        bcnt_next = bcnt_reg;
        h1_next   = h1_reg;
        h2_next   = h2_reg;
        if (cmd.load_in)
        begin
            hkey_next = in_key;
            bcnt_next = '0;
            h1_next   = hash_select ? MUR_INIT : DJB_INIT;
            h2_next   = AUX_INIT;
        end
        else if (cmd.hash_step)
        begin
            hkey_next = {hkey_reg[KEY_W-9:0], 8'd0};
            bcnt_next = bcnt_reg + 3'd1;
            h1_next   = hash_select ? (mur_p ^ (mur_p >> 15))
                                    : ((h1_reg << 5) + h1_reg + {24'd0, hbyte});
            h2_next   = h2_reg + aux_r;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        pcnt_next = pcnt_reg;
        if (cmd.load_in)
        begin
            pcnt_next = '0;
        end
        if (cmd.probe_init)
        begin
            pos_next = h1_reg;
        end
        if (cmd.probe_rd)
        begin
            pcnt_next = pcnt_reg + CNT_W'(1);
        end
        if (cmd.probe_adv)
        begin
            pos_next = pos_reg + {21'd0, h2_reg};
        end
        ecnt_next = ecnt_reg;
        if (cmd.wr_insert)
        begin
            ecnt_next = ecnt_reg + 16'd1;
        end
        else if (cmd.wr_delete && ecnt_reg != 16'd0)
        begin
            ecnt_next = ecnt_reg - 16'd1;
        end
    end

    // Entry layout: occupied, tombstone, key.
    always_comb
    begin
        ram_we    = cmd.clear_wr | cmd.wr_insert | cmd.wr_delete;
        ram_waddr = cmd.clear_wr ? clr_reg : idx;
        if (cmd.wr_insert)
        begin
            ram_wdata = {1'b1, 1'b0, key_reg};
        end
        else if (cmd.wr_delete)
        begin
            ram_wdata = {1'b0, 1'b1, ram_rdata[KEY_W-1:0]};
        end
        else
        begin
            ram_wdata = '0;
        end
    end

    dhot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        st.op         = op_reg;
        st.table_full = (ecnt_reg >= 16'(TABLE_SIZE));
        st.hash_last  = (bcnt_reg == 3'(KEY_BYTES - 1));
        st.walk_end   = (pcnt_reg == CNT_W'(TABLE_SIZE))
                        || (pcnt_reg != '0 && idx == h1_reg[IDX_W-1:0]);
        st.occ        = ram_rdata[ENTRY_W-1];
        st.tomb       = ram_rdata[ENTRY_W-2];
        st.key_match  = (ram_rdata[KEY_W-1:0] == key_reg);
        st.clear_last = (clr_reg == IDX_W'(TABLE_SIZE - 1));
        st.out_free   = !ovalid_reg || m_tready;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'd0, rprobe_reg, rslot_reg, rstat_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= in_op;
            key_reg <= in_key;
        end
        hkey_reg <= hkey_next;
        bcnt_reg <= bcnt_next;
        h1_reg   <= h1_next;
        h2_reg   <= h2_next;
        pos_reg  <= pos_next;
        pcnt_reg <= pcnt_next;
        if (cmd.res_load)
        begin
            rstat_reg  <= cmd.res_status;
            rslot_reg  <= cmd.res_use_slot ? idx : '0;
            rprobe_reg <= 16'(pcnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            ecnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            ecnt_reg <= ecnt_next;
            if (cmd.res_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/double_hash_open_table.sv =====
// ----------------------------------------------------------------------------
// double_hash_open_table
// Open-addressed key table with double hashing, tombstone delete and APB setup.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_*       in         command transfer: tdata = command[1:0], key[57:2]
//  m_*       out        result transfer: status[1:0], slot[16:2], probe_count[32:17]
//  APB       in/out     register 0 at address 0: hash_select (bit 0)
//
//  After reset a clearing pass writes all 32768 table entries, one per cycle,
//  so no command is taken until the pass ends; register writes work.
//  An operation is decoded, then its key is hashed one byte per cycle, then
//  a setup step starts the probe walk; each probe is a memory read, then a
//  compare and write, and a final step hands the result to the output
//  register when the output is free.
//  A new command is accepted while an earlier result waits in the output
//  register; a stalled output holds the sequencer at its final step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_hash_open_table_macros.svh"

module double_hash_open_table
    import dhot_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // command[1:0], key[57:2], zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // status[1:0], slot[16:2], probe_count[32:17]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    dhot_cmd_t  cmd;
    dhot_stat_t st;
    logic       hsel_reg;

    // The only register is hash_select, decoded from paddr[2] alone; addresses 4 to 7 read as zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, hsel_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsel_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            hsel_reg <= pwdata[0];
        end
    end

    dhot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dhot_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_op       (s_tdata[1:0]),
        .in_key      (s_tdata[KEY_W+1:2]),
        .hash_select (hsel_reg),
        .m_tready    (m_tready),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

    // One operation in flight: acceptance closes the input until it ends.
    `DHOT_ASSERT_NEXT(a_one_op, s_tvalid && s_tready, !s_tready, "second command taken mid-operation")
    // At most one kind of table write per cycle.
    `DHOT_ASSERT_SAME(a_one_write, 1'b1, $onehot0({cmd.clear_wr, cmd.wr_insert, cmd.wr_delete}), "conflicting table writes")
    // Any failure reports slot zero.
    `DHOT_ASSERT_SAME(a_fail_slot, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[16:2] == '0, "failure with nonzero slot")

endmodule

`default_nettype wire

// ===== test/double_hash_open_table_tb.sv =====
// ----------------------------------------------------------------------------
// double_hash_open_table_tb
// Checks the double hash open table against a cycle-free table predictor.
// Directed commands come first, then keys that share one short probe cycle,
// then random command streams under both primary hashes with random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_hash_open_table_tb;
    import dhot_pkg::*;

    // Command code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Register index of hash_select and its APB byte address.
    localparam int         REG_HASH_SELECT = 0;
    localparam logic [2:0] ADDR_HASH_SELECT = 3'(4 * REG_HASH_SELECT);
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 200000;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int CLASS_KEYS = 70;
    // Commands in each random stretch.
    localparam int PHASE_ITEMS = 320;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] slot;
        logic [15:0] probes;
    } result_t;

    typedef struct {
        logic [1:0]  op;
        logic [55:0] key;
        bit          typed;
        result_t     want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: a mirror of the table and the register.
    logic [55:0] mirror_key  [TABLE_SIZE];
    bit          mirror_occ  [TABLE_SIZE];
    bit          mirror_tomb [TABLE_SIZE];
    int          mirror_entries;
    bit          mirror_murmur;

    result_t     pending_results[$];
    logic [55:0] class_keys[$];
    logic [55:0] key_pool[$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_request;
    bit          quiet_mode;

    double_hash_open_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Byte i of the key, first byte in the most significant position.
    function automatic logic [31:0] key_byte(logic [55:0] key, int i);
        return 32'((key >> (8 * (KEY_BYTES - 1 - i))) & 56'hFF);
    endfunction

    function automatic logic [31:0] home_hash(logic [55:0] key, bit murmur);
        logic [31:0] h;
        h = murmur ? MUR_INIT : DJB_INIT;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (murmur)
            begin
                h = h ^ key_byte(key, i);
                h = h * MUR_MULT;
                h = h ^ (h >> 15);
            end
            else
            begin
                h = (h << 5) + h + key_byte(key, i);
            end
        end
        return h;
    endfunction

    function automatic logic [31:0] stride_hash(logic [55:0] key);
        logic [31:0] h;
        h = 32'(AUX_INIT);
        for (int i = 0; i < KEY_BYTES; i++)
            h = h + key_byte(key, i) % h;
        return h;
    endfunction

    // Applies one command to the mirror table and returns what the block
    // should answer. The walk ends after a full table's worth of probes or
    // when the sequence comes back around to its home slot.
    function automatic result_t apply_table_op(logic [1:0] op, logic [55:0] key);
        result_t     r;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] idx;
        logic [14:0] home;
        logic [14:0] s;
        r.status = ST_NOTFOUND;
        r.slot   = '0;
        r.probes = '0;
        if (op == OP_INSERT && mirror_entries >= TABLE_SIZE)
        begin
            r.status = ST_FULL;
        end
        else if (op != OP_UNUSED)
        begin
            h1 = home_hash(key, mirror_murmur);
            h2 = stride_hash(key);
            home = h1[14:0];
            r.status = (op == OP_INSERT) ? ST_FULL : ST_NOTFOUND;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                idx = h1 + 32'(i) * h2;
                s = idx[14:0];
                if (i > 0 && s == home)
                    break;
                r.probes++;
                if (op == OP_INSERT)
                begin
                    if (!mirror_occ[s])
                    begin
                        mirror_key[s]  = key;
                        mirror_occ[s]  = 1'b1;
                        mirror_tomb[s] = 1'b0;
                        mirror_entries++;
                        r.status = ST_OK;
                        r.slot   = s;
                        break;
                    end
                    if (mirror_key[s] == key)
                    begin
                        r.status = ST_DUP;
                        break;
                    end
                end
                else
                begin
                    if (!mirror_occ[s] && !mirror_tomb[s])
                        break;
                    if (mirror_occ[s] && mirror_key[s] == key)
                    begin
                        r.status = ST_OK;
                        r.slot   = s;
                        if (op == OP_DELETE)
                        begin
                            mirror_occ[s]  = 1'b0;
                            mirror_tomb[s] = 1'b1;
                            if (mirror_entries > 0)
                                mirror_entries--;
                        end
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // Builds djb2 keys whose stride is a multiple of 512 and whose home slots
    // agree modulo 512, so they all walk within the same 64 slots. The last
    // byte moves both hashes by the same amount, which makes it solvable.
    task automatic build_class_keys();
        logic [47:0] prefix;
        logic [31:0] part_home;
        logic [31:0] part_stride;
        logic [31:0] need;
        logic [31:0] h1;
        int          residue;
        residue = -1;
        while (class_keys.size() < CLASS_KEYS)
        begin
            prefix = 48'({$urandom, $urandom});
            part_home = DJB_INIT;
            part_stride = 32'(AUX_INIT);
            for (int i = 0; i < KEY_BYTES - 1; i++)
            begin
                part_home = (part_home << 5) + part_home + 32'((prefix >> (8 * (5 - i))) & 48'hFF);
                part_stride = part_stride + 32'((prefix >> (8 * (5 - i))) & 48'hFF) % part_stride;
            end
            need = (32'd512 - (part_stride % 32'd512)) % 32'd512;
            if (need <= 32'd255 && need < part_stride)
            begin
                h1 = (part_home << 5) + part_home + need;
                if (residue < 0)
                    residue = int'(h1[8:0]);
                if (int'(h1[8:0]) == residue)
                    class_keys.push_back({prefix, need[7:0]});
            end
        end
    endtask

    // Offers one command, waits for its transfer, then records the answer.
    task automatic send_command(logic [1:0] op, logic [55:0] key, bit typed, result_t want);
        int      gap;
        result_t got;
        gap = quiet_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, key, op};
        do
            @(posedge clk);
        while (!s_tready);
        got = apply_table_op(op, key);
        pending_results.push_back(typed ? want : got);
    endtask

    task automatic write_hash_select(bit value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_HASH_SELECT;
        pwdata  <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // The write lands on this edge: pready is always high.
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror_murmur = value;
    endtask

    // Brings the block to idle before a register change: the command input
    // is dropped, every answer is back and the task waits on past that.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [55:0] random_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (pick < 95)
            return 56'({$urandom, $urandom});
        else
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    function automatic logic [1:0] random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return OP_INSERT;
        else if (pick < 70)
            return OP_SEARCH;
        else if (pick < 95)
            return OP_DELETE;
        else
            return OP_UNUSED;
    endfunction

    task automatic random_phase(int count, bit with_hold_off);
        result_t none;
        none = '0;
        for (int n = 0; n < count; n++)
        begin
            // Switch between gap-free stretches and randomly idling ones.
            if (n % 50 == 0)
                quiet_mode = ($urandom_range(0, 3) == 0);
            if (with_hold_off && n == count / 2)
                hold_request = 1'b1;
            send_command(random_op(), random_key(), 1'b0, none);
        end
        quiet_mode = 1'b0;
    endtask

    // Receiver: random ready gaps, one long hold-off on request, and the
    // field-by-field check of every result transfer.
    initial
    begin
        int      gap;
        result_t got;
        result_t want;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = quiet_mode ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            got.status = m_tdata[1:0];
            got.slot   = m_tdata[16:2];
            got.probes = m_tdata[32:17];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result status=%0d slot=%0d probes=%0d",
                         $time, got.status, got.slot, got.probes);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                end
                if (got.slot !== want.slot)
                begin
                    mismatches++;
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
                end
                if (got.probes !== want.probes)
                begin
                    mismatches++;
                    $display("%0t: probe_count expected %0d actual %0d",
                             $time, want.probes, got.probes);
                end
            end
        end
    end

    // Watchdog on cycles in which no transfer of any kind happens.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        row_t    rows[$];
        result_t none;
        none = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        mismatches    = 0;
        idle_cycles   = 0;
        hold_request  = 1'b0;
        quiet_mode    = 1'b0;
        mirror_entries = 0;
        mirror_murmur  = 1'b0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            mirror_occ[i]  = 1'b0;
            mirror_tomb[i] = 1'b0;
            mirror_key[i]  = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed answers: an empty table misses on its first
        // probe, the unused command does nothing, and a repeated insert of a
        // key at its home slot is a duplicate after one probe.
        rows = '{
            '{OP_SEARCH, 56'h0,              1'b1, '{ST_NOTFOUND, 15'd0, 16'd1}},
            '{OP_UNUSED, 56'hFF_FFFF_FFFF_FFFF, 1'b1, '{ST_NOTFOUND, 15'd0, 16'd0}},
            '{OP_INSERT, 56'h0,              1'b0, none},
            '{OP_INSERT, 56'h0,              1'b1, '{ST_DUP, 15'd0, 16'd1}},
            '{OP_SEARCH, 56'h0,              1'b0, none},
            '{OP_INSERT, 56'hFF_FFFF_FFFF_FFFF, 1'b0, none},
            '{OP_SEARCH, 56'hFF_FFFF_FFFF_FFFF, 1'b0, none},
            '{OP_DELETE, 56'h0,              1'b0, none},
            '{OP_SEARCH, 56'h0,              1'b0, none},
            '{OP_DELETE, 56'h0,              1'b0, none},
            '{OP_INSERT, 56'h0,              1'b0, none},
            '{OP_SEARCH, 56'h0,              1'b0, none},
            '{OP_DELETE, 56'hFF_FFFF_FFFF_FFFF, 1'b0, none},
            '{OP_SEARCH, 56'hFF_FFFF_FFFF_FFFF, 1'b0, none},
            '{OP_INSERT, 56'hAA_AAAA_AAAA_AAAA, 1'b0, none},
            '{OP_INSERT, 56'h55_5555_5555_5555, 1'b0, none},
            '{OP_SEARCH, 56'h55_5555_5555_5555, 1'b0, none},
            '{OP_DELETE, 56'hAA_AAAA_AAAA_AAAA, 1'b0, none},
            '{OP_UNUSED, 56'h0,              1'b1, '{ST_NOTFOUND, 15'd0, 16'd0}},
            '{OP_INSERT, 56'h01_0203_0405_0607, 1'b0, none}
        };
        write_hash_select(1'b0);
        foreach (rows[i])
            send_command(rows[i].op, rows[i].key, rows[i].typed, rows[i].want);

        // Keys sharing one short probe cycle: the cycle fills, later inserts
        // come back to their home slot and answer full, absent keys walk the
        // whole cycle, and deletes leave tombstones for the next walks.
        build_class_keys();
        foreach (class_keys[i])
            send_command(OP_INSERT, class_keys[i], 1'b0, none);
        foreach (class_keys[i])
            send_command(OP_SEARCH, class_keys[i], 1'b0, none);
        for (int i = 0; i < 10; i++)
            send_command(OP_DELETE, class_keys[i * 3], 1'b0, none);
        foreach (class_keys[i])
            send_command(OP_SEARCH, class_keys[i], 1'b0, none);
        for (int i = 0; i < 6; i++)
            send_command(OP_INSERT, class_keys[CLASS_KEYS - 1 - i], 1'b0, none);
        drain_results();

        for (int i = 0; i < 48; i++)
            key_pool.push_back(56'({$urandom, $urandom}));
        for (int i = 0; i < 8; i++)
            key_pool.push_back(class_keys[i]);

        write_hash_select(1'b1);
        random_phase(PHASE_ITEMS, 1'b1);
        drain_results();
        write_hash_select(1'b0);
        random_phase(PHASE_ITEMS, 1'b0);
        drain_results();
        write_hash_select(1'b1);
        random_phase(PHASE_ITEMS, 1'b0);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
